/* src/bfpa_pkg.sv */
// Shared constants, codes and types of the best-fit partition allocator.
`default_nettype none
package bfpa_pkg;

   // table geometry and field widths
   localparam int MaxParts  = 8;
   localparam int IdxBits   = 3;
   localparam int CntBits   = 4;
   localparam int AddrBits  = 10;
   localparam int OwnerBits = 4;
   localparam int FuncBits  = 2;
   localparam int StatBits  = 2;
   localparam int CfgBits   = 4;

   // request codes
   localparam logic [FuncBits-1:0] FUNC_ALLOC   = 2'd0;
   localparam logic [FuncBits-1:0] FUNC_RELEASE = 2'd1;
   localparam logic [FuncBits-1:0] FUNC_LOAD    = 2'd2;

   // result status codes
   localparam logic [StatBits-1:0] ST_OK        = 2'd0;
   localparam logic [StatBits-1:0] ST_TOO_BIG   = 2'd1;
   localparam logic [StatBits-1:0] ST_FULL      = 2'd2;
   localparam logic [StatBits-1:0] ST_NOT_FOUND = 2'd3;

   // table write controls
   typedef struct packed {
      logic                 load;
      logic                 set_busy;
      logic                 clr_busy;
      logic [IdxBits-1:0]   idx;
      logic [AddrBits-1:0]  start;
      logic [AddrBits-1:0]  length;
      logic [OwnerBits-1:0] owner;
   } tbl_wr_type;

   // registered entry read back from the table
   typedef struct packed {
      logic [AddrBits-1:0] start;
      logic [AddrBits-1:0] length;
      logic                busy;
   } tbl_rd_type;

endpackage
`default_nettype wire

/* src/best_fit_partition_allocator.sv */
// Top level: request/response streams, config register and scan sequencer.
//
// Best-fit fixed-partition allocator.
// Requests arrive on req_* (tdata: func, request_size, owner_id, start_address,
// entry_index from bit 0 up); one response per request leaves on rsp_*
// (tdata: status, chosen_index, chosen_address from bit 0 up).
// csr_* is an APB-style port holding partitions_in_use at byte address 0.
// Allocate and release walk the table one entry a cycle through a single
// compare unit fed by the registered table read port; a release stops at
// its first match. Load, unused codes and scans over an empty table skip the
// scan and go straight to the result. req_tready comes back as the result
// moves to the output register.
// One request is in flight at a time; req_tready is high only when idle.
// The response sits in an output register, so the next request can be taken
// while the previous response still waits; the sequencer then holds its
// result until the output register frees up.
// Reset clears the busy flags, owners, register and control state; start and
// length entries are undefined until loaded.
`default_nettype none
module best_fit_partition_allocator (
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [1:0] func, [11:2] request_size, [15:12] owner_id,
   // [25:16] start_address, [28:26] entry_index, [31:29] zero
   input  wire logic [31:0] req_tdata,
   // response stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [1:0] status, [4:2] chosen_index, [14:5] chosen_address, [15] zero
   output logic [15:0]      rsp_tdata,
   // configuration port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   // request fields
   logic [bfpa_pkg::FuncBits-1:0]  req_func;
   logic [bfpa_pkg::AddrBits-1:0]  req_size;
   logic [bfpa_pkg::OwnerBits-1:0] req_owner;
   logic [bfpa_pkg::AddrBits-1:0]  req_addr;
   logic [bfpa_pkg::IdxBits-1:0]   req_entry;

   assign req_func  = req_tdata[1:0];
   assign req_size  = req_tdata[11:2];
   assign req_owner = req_tdata[15:12];
   assign req_addr  = req_tdata[25:16];
   assign req_entry = req_tdata[28:26];

   logic [1:0]                     state_ff, state_in;
   logic [bfpa_pkg::CfgBits-1:0]   cfg_ff, cfg_in;
   logic [bfpa_pkg::FuncBits-1:0]  func_ff, func_in;
   logic [bfpa_pkg::AddrBits-1:0]  size_ff, size_in;
   logic [bfpa_pkg::OwnerBits-1:0] own_ff, own_in;
   logic [bfpa_pkg::AddrBits-1:0]  addr_ff, addr_in;
   logic [bfpa_pkg::CntBits-1:0]   issue_ff, issue_in;
   logic                           cmp_vld_ff, cmp_vld_in;
   logic [bfpa_pkg::IdxBits-1:0]   cmp_idx_ff, cmp_idx_in;
   logic                           any_fits_ff, any_fits_in;
   logic                           have_best_ff, have_best_in;
   logic [bfpa_pkg::IdxBits-1:0]   best_idx_ff, best_idx_in;
   logic [bfpa_pkg::AddrBits-1:0]  best_len_ff, best_len_in;
   logic [bfpa_pkg::AddrBits-1:0]  best_start_ff, best_start_in;
   logic [bfpa_pkg::StatBits-1:0]  res_stat_ff, res_stat_in;
   logic [bfpa_pkg::IdxBits-1:0]   res_idx_ff, res_idx_in;
   logic [bfpa_pkg::AddrBits-1:0]  res_addr_ff, res_addr_in;
   logic                           rsp_vld_ff, rsp_vld_in;
   logic [bfpa_pkg::StatBits-1:0]  rsp_stat_ff, rsp_stat_in;
   logic [bfpa_pkg::IdxBits-1:0]   rsp_idx_ff, rsp_idx_in;
   logic [bfpa_pkg::AddrBits-1:0]  rsp_addr_ff, rsp_addr_in;

   logic [bfpa_pkg::CntBits-1:0]   active_n;
   logic                           req_acc;
   logic                           cfg_wr;
   logic                           out_free;
   logic                           issue;
   logic                           last_cmp;
   logic                           fits, better, take, match;
   bfpa_pkg::tbl_wr_type           tbl_wr;
   bfpa_pkg::tbl_rd_type           tbl_rd;
   logic [bfpa_pkg::IdxBits-1:0]   rd_idx;

   // configuration register
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg_in     = (cfg_wr && !csr_paddr[2]) ? csr_pwdata[bfpa_pkg::CfgBits-1:0] : cfg_ff;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {{(32 - bfpa_pkg::CfgBits){1'b0}}, cfg_ff};

   // active entry count, clamped to the table size
   assign active_n = (cfg_ff > bfpa_pkg::CfgBits'(bfpa_pkg::MaxParts))
                   ? bfpa_pkg::CntBits'(bfpa_pkg::MaxParts)
                   : bfpa_pkg::CntBits'(cfg_ff);

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid & req_tready;
   assign out_free   = !rsp_vld_ff || rsp_tready;

   // shared compare unit on the entry returned by the table
   assign fits     = (tbl_rd.length >= size_ff);
   assign better   = !have_best_ff || (tbl_rd.length < best_len_ff);
   assign take     = fits && !tbl_rd.busy && better;
   assign match    = (tbl_rd.start == addr_ff);
   assign last_cmp = cmp_vld_ff &&
                     (({1'b0, cmp_idx_ff} == active_n - bfpa_pkg::CntBits'(1)) ||
                      (func_ff == bfpa_pkg::FUNC_RELEASE && match));

   assign issue  = (state_ff == S_SCAN) && (issue_ff < active_n) && !last_cmp;
   assign rd_idx = issue_ff[bfpa_pkg::IdxBits-1:0];

   // sequencer
   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      size_in       = size_ff;
      own_in        = own_ff;
      addr_in       = addr_ff;
      issue_in      = issue_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      any_fits_in   = any_fits_ff;
      have_best_in  = have_best_ff;
      best_idx_in   = best_idx_ff;
      best_len_in   = best_len_ff;
      best_start_in = best_start_ff;
      res_stat_in   = res_stat_ff;
      res_idx_in    = res_idx_ff;
      res_addr_in   = res_addr_ff;
      rsp_vld_in    = rsp_vld_ff;
      rsp_stat_in   = rsp_stat_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_addr_in   = rsp_addr_ff;
      tbl_wr        = '0;

      // response register drains independently of the sequencer
      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               func_in      = req_func;
               size_in      = req_size;
               own_in       = req_owner;
               addr_in      = req_addr;
               issue_in     = '0;
               any_fits_in  = 1'b0;
               have_best_in = 1'b0;
               res_stat_in  = bfpa_pkg::ST_OK;
               res_idx_in   = '0;
               res_addr_in  = '0;
               state_in     = S_DONE;
               case (req_func)
                  bfpa_pkg::FUNC_ALLOC: begin
                     if (active_n == '0) begin
                        res_stat_in = bfpa_pkg::ST_TOO_BIG;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  bfpa_pkg::FUNC_RELEASE: begin
                     if (active_n == '0) begin
                        res_stat_in = bfpa_pkg::ST_NOT_FOUND;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  bfpa_pkg::FUNC_LOAD: begin
                     if (int'(req_entry) < bfpa_pkg::MaxParts) begin
                        tbl_wr.load   = 1'b1;
                        tbl_wr.idx    = req_entry;
                        tbl_wr.start  = req_addr;
                        tbl_wr.length = req_size;
                        res_idx_in    = req_entry;
                        res_addr_in   = req_addr;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_SCAN: begin
            // issue the next table read
            if (issue) begin
               issue_in   = issue_ff + bfpa_pkg::CntBits'(1);
               cmp_vld_in = 1'b1;
               cmp_idx_in = rd_idx;
            end
            // fold in the entry read last cycle
            if (cmp_vld_ff) begin
               if (func_ff == bfpa_pkg::FUNC_ALLOC) begin
                  any_fits_in = any_fits_ff | fits;
                  if (take) begin
                     have_best_in  = 1'b1;
                     best_idx_in   = cmp_idx_ff;
                     best_len_in   = tbl_rd.length;
                     best_start_in = tbl_rd.start;
                  end
               end
            end
            // commit on the last entry or a release hit
            if (last_cmp) begin
               state_in   = S_DONE;
               cmp_vld_in = 1'b0;
               if (func_ff == bfpa_pkg::FUNC_ALLOC) begin
                  if (!any_fits_in) begin
                     res_stat_in = bfpa_pkg::ST_TOO_BIG;
                  end else if (!have_best_in) begin
                     res_stat_in = bfpa_pkg::ST_FULL;
                  end else begin
                     res_stat_in     = bfpa_pkg::ST_OK;
                     res_idx_in      = best_idx_in;
                     res_addr_in     = best_start_in;
                     tbl_wr.set_busy = 1'b1;
                     tbl_wr.idx      = best_idx_in;
                     tbl_wr.owner    = own_ff;
                  end
               end else if (match) begin
                  res_stat_in     = bfpa_pkg::ST_OK;
                  res_idx_in      = cmp_idx_ff;
                  res_addr_in     = tbl_rd.start;
                  tbl_wr.clr_busy = 1'b1;
                  tbl_wr.idx      = cmp_idx_ff;
               end else begin
                  res_stat_in = bfpa_pkg::ST_NOT_FOUND;
               end
            end
         end

         S_DONE: begin
            // hand the result over once the output register is free
            if (out_free) begin
               rsp_vld_in  = 1'b1;
               rsp_stat_in = res_stat_ff;
               rsp_idx_in  = res_idx_ff;
               rsp_addr_in = res_addr_ff;
               state_in    = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cfg_ff     <= '0;
         cmp_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cfg_ff     <= cfg_in;
         cmp_vld_ff <= cmp_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      size_ff       <= size_in;
      own_ff        <= own_in;
      addr_ff       <= addr_in;
      issue_ff      <= issue_in;
      cmp_idx_ff    <= cmp_idx_in;
      any_fits_ff   <= any_fits_in;
      have_best_ff  <= have_best_in;
      best_idx_ff   <= best_idx_in;
      best_len_ff   <= best_len_in;
      best_start_ff <= best_start_in;
      res_stat_ff   <= res_stat_in;
      res_idx_ff    <= res_idx_in;
      res_addr_ff   <= res_addr_in;
      rsp_stat_ff   <= rsp_stat_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   bfpa_table u_table (
      .clock  (clock),
      .reset  (reset),
      .wr     (tbl_wr),
      .rd_idx (rd_idx),
      .rd     (tbl_rd)
   );

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {1'b0, rsp_addr_ff, rsp_idx_ff, rsp_stat_ff};

   // a taken request closes the request side on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_tready)
      else $error("request side still open after accepting a request");

   // failed allocations and misses report index and address as zero
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_stat_ff != bfpa_pkg::ST_OK) |->
      (rsp_idx_ff == '0 && rsp_addr_ff == '0))
      else $error("non-ok response carries index or address");

   // the scan never runs past the active entries
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (issue_ff <= active_n))
      else $error("scan index beyond active entry count");

   // a finished result leaves the sequencer as soon as the output is free
   a_done_drains: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !rsp_vld_ff) |=> (state_ff == S_IDLE && rsp_vld_ff))
      else $error("result held back with a free output register");

   // only one table write kind at a time
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({tbl_wr.load, tbl_wr.set_busy, tbl_wr.clr_busy}))
      else $error("conflicting table writes");

endmodule
`default_nettype wire

/* src/bfpa_table.sv */
// Partition table: start and length memories, busy flags and owners.
`default_nettype none
module bfpa_table (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bfpa_pkg::tbl_wr_type wr,
   input  wire logic [bfpa_pkg::IdxBits-1:0] rd_idx,
   output bfpa_pkg::tbl_rd_type      rd
);

   logic [bfpa_pkg::AddrBits-1:0]  start_mem [bfpa_pkg::MaxParts];
   logic [bfpa_pkg::AddrBits-1:0]  len_mem   [bfpa_pkg::MaxParts];
   logic [bfpa_pkg::MaxParts-1:0]  busy_ff;
   logic [bfpa_pkg::OwnerBits-1:0] owner_ff  [bfpa_pkg::MaxParts];
   bfpa_pkg::tbl_rd_type           rd_ff;

   // start and length: written on load, read with registered data
   always_ff @(posedge clock) begin
      if (wr.load) begin
         start_mem[wr.idx] <= wr.start;
         len_mem[wr.idx]   <= wr.length;
      end
      rd_ff.start  <= start_mem[rd_idx];
      rd_ff.length <= len_mem[rd_idx];
      rd_ff.busy   <= busy_ff[rd_idx];
   end

   // busy flags and owners clear at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
         for (int i = 0; i < bfpa_pkg::MaxParts; i++) begin
            owner_ff[i] <= '0;
         end
      end else if (wr.load) begin
         busy_ff[wr.idx]  <= 1'b0;
         owner_ff[wr.idx] <= '0;
      end else if (wr.set_busy) begin
         busy_ff[wr.idx]  <= 1'b1;
         owner_ff[wr.idx] <= wr.owner;
      end else if (wr.clr_busy) begin
         busy_ff[wr.idx]  <= 1'b0;
      end
   end

   assign rd = rd_ff;

endmodule
`default_nettype wire

/* sim/bfpa_checker.sv */
// Response checker for the best-fit partition allocator: predicts from requests and compares.
`default_nettype none
module bfpa_checker
   import bfpa_pkg::*;
#(
   parameter logic [2:0] PartsInUseAddr = 3'd0
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   // [1:0] func, [11:2] request_size, [15:12] owner_id,
   // [25:16] start_address, [28:26] entry_index, [31:29] zero
   input  wire logic [31:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // [1:0] status, [4:2] chosen_index, [14:5] chosen_address, [15] zero
   input  wire logic [15:0] rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   input  wire logic        csr_pready,
   output int               fail_count,
   output int               outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // request and response layouts, lowest field last
   typedef struct packed {
      logic [2:0]           pad;
      logic [IdxBits-1:0]   entry;
      logic [AddrBits-1:0]  start;
      logic [OwnerBits-1:0] owner;
      logic [AddrBits-1:0]  size;
      logic [FuncBits-1:0]  func;
   } alloc_req_t;

   typedef struct packed {
      logic                pad;
      logic [AddrBits-1:0] addr;
      logic [IdxBits-1:0]  idx;
      logic [StatBits-1:0] status;
   } alloc_rsp_t;

   // shadow partition table and register
   logic [AddrBits-1:0]  tbl_start  [MaxParts];
   logic [AddrBits-1:0]  tbl_length [MaxParts];
   logic                 tbl_busy   [MaxParts];
   logic [OwnerBits-1:0] tbl_owner  [MaxParts];
   logic [CfgBits-1:0]   parts_in_use;

   alloc_rsp_t expected_rsp [$];

   // best-fit allocate, first-match release, entry load; updates the shadow table
   function automatic alloc_rsp_t table_response(alloc_req_t r);
      alloc_rsp_t o;
      int         n;
      int         i;
      int         best;
      logic       any_fits;
      logic       have_best;
      logic       found;
      o         = '0;
      n         = (parts_in_use > MaxParts) ? MaxParts : int'(parts_in_use);
      best      = 0;
      any_fits  = 1'b0;
      have_best = 1'b0;
      found     = 1'b0;
      case (r.func)
         FUNC_ALLOC: begin
            for (i = 0; i < n; i++) begin
               if (tbl_length[i] >= r.size) begin
                  any_fits = 1'b1;
                  if (!tbl_busy[i] && (!have_best || tbl_length[i] < tbl_length[best])) begin
                     have_best = 1'b1;
                     best      = i;
                  end
               end
            end
            if (!any_fits) begin
               o.status = ST_TOO_BIG;
            end else if (!have_best) begin
               o.status = ST_FULL;
            end else begin
               tbl_busy[best]  = 1'b1;
               tbl_owner[best] = r.owner;
               o.status        = ST_OK;
               o.idx           = IdxBits'(best);
               o.addr          = tbl_start[best];
            end
         end
         FUNC_RELEASE: begin
            // matched on address alone, so a free entry still answers ok
            for (i = 0; i < n; i++) begin
               if (!found && tbl_start[i] == r.start) begin
                  found       = 1'b1;
                  tbl_busy[i] = 1'b0;
                  o.idx       = IdxBits'(i);
                  o.addr      = tbl_start[i];
               end
            end
            if (!found) o.status = ST_NOT_FOUND;
         end
         FUNC_LOAD: begin
            tbl_start[r.entry]  = r.start;
            tbl_length[r.entry] = r.size;
            tbl_busy[r.entry]   = 1'b0;
            tbl_owner[r.entry]  = '0;
            o.idx               = r.entry;
            o.addr              = r.start;
         end
         default: ;
      endcase
      return o;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] %s", $time, msg);
      fail_count++;
   endtask

   // compare first, so a response never meets the request taken on the same edge
   always @(posedge clock) begin
      alloc_rsp_t got;
      alloc_rsp_t want;
      if (reset) begin
         expected_rsp.delete();
         parts_in_use = '0;
         for (int i = 0; i < MaxParts; i++) begin
            tbl_start[i]  = '0;
            tbl_length[i] = '0;
            tbl_busy[i]   = 1'b0;
            tbl_owner[i]  = '0;
         end
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = alloc_rsp_t'(rsp_tdata);
            if (expected_rsp.size() == 0) begin
               report_mismatch($sformatf("response %h with no request waiting", rsp_tdata));
            end else begin
               want = expected_rsp.pop_front();
               if (got.status !== want.status)
                  report_mismatch($sformatf("status: got %0d, want %0d", got.status, want.status));
               if (got.idx !== want.idx)
                  report_mismatch($sformatf("chosen_index: got %0d, want %0d", got.idx, want.idx));
               if (got.addr !== want.addr)
                  report_mismatch($sformatf("chosen_address: got %0d, want %0d",
                                            got.addr, want.addr));
            end
         end
         if (req_tvalid && req_tready)
            expected_rsp.push_back(table_response(alloc_req_t'(req_tdata)));
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == PartsInUseAddr)
            parts_in_use = csr_pwdata[CfgBits-1:0];
      end
      outstanding <= expected_rsp.size();
   end

endmodule
`default_nettype wire

/* sim/tb.sv */
// Testbench top for the best-fit partition allocator: clock, reset, stimulus and verdict.
`default_nettype none
module tb;
   import bfpa_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [FuncBits-1:0] FuncUnused     = 2'd3;
   localparam logic [2:0]          PartsInUseAddr = 3'd0;
   localparam int                  SettleCycles   = 16;
   localparam int                  LongHold       = 150;
   localparam int                  PhaseItems     = 75;
   localparam int                  CycleLimit     = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int fail_count;
   int outstanding;
   int cycle_count = 0;
   bit idle_on = 1'b1;
   bit long_hold = 1'b0;
   int cur_parts = 0;
   int shadow_start [MaxParts];
   int shadow_len   [MaxParts];

   always #10 clock = ~clock;

   best_fit_partition_allocator DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   bfpa_checker #(.PartsInUseAddr(PartsInUseAddr)) rsp_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // response side: random back-pressure, one long hold-off on demand
   initial begin
      forever begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (LongHold) @(posedge clock);
            long_hold = 1'b0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // offer one request and hold it until taken
   task automatic send_request(input logic [FuncBits-1:0] func, input int size, input int owner,
                               input int addr, input int entry);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, entry[IdxBits-1:0], addr[AddrBits-1:0], owner[OwnerBits-1:0],
                     size[AddrBits-1:0], func};
      do @(posedge clock); while (!req_tready);
      if (func == FUNC_LOAD) begin
         shadow_start[entry[IdxBits-1:0]] = addr;
         shadow_len[entry[IdxBits-1:0]]   = size;
      end
   endtask

   // stop offering and wait for the block to drain
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_parts_in_use(input int value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= PartsInUseAddr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cur_parts = value;
   endtask

   // mostly sizes and addresses taken from the loaded table, some noise
   task automatic random_request(output bit counted);
      int pick;
      int k;
      int active;
      int size;
      int addr;
      active  = (cur_parts > MaxParts) ? MaxParts : cur_parts;
      k       = $urandom_range(0, (active > 0) ? active - 1 : MaxParts - 1);
      pick    = $urandom_range(0, 99);
      counted = 1'b1;
      if (pick < 45) begin
         case ($urandom_range(0, 5))
            0:       size = $urandom_range(0, 1023);
            1:       size = $urandom_range(0, 15);
            default: size = shadow_len[k] + int'($urandom_range(0, 4)) - 2;
         endcase
         if (size < 0) size = 0;
         if (size > 1023) size = 1023;
         send_request(FUNC_ALLOC, size, $urandom_range(0, 15), $urandom_range(0, 1023),
                      $urandom_range(0, 7));
      end else if (pick < 80) begin
         addr = ($urandom_range(0, 4) != 0) ? shadow_start[k] : $urandom_range(0, 1023);
         send_request(FUNC_RELEASE, $urandom_range(0, 1023), $urandom_range(0, 15), addr,
                      $urandom_range(0, 7));
      end else if (pick < 95) begin
         case ($urandom_range(0, 2))
            0:       addr = $urandom_range(0, 1023);
            1:       addr = $urandom_range(0, 15) * 64;
            default: addr = shadow_start[$urandom_range(0, MaxParts - 1)];
         endcase
         case ($urandom_range(0, 2))
            0:       size = $urandom_range(0, 1023);
            1:       size = $urandom_range(0, 63);
            default: size = shadow_len[$urandom_range(0, MaxParts - 1)];
         endcase
         send_request(FUNC_LOAD, size, $urandom_range(0, 15), addr, $urandom_range(0, 7));
      end else begin
         counted = 1'b0;
         send_request(FuncUnused, $urandom_range(0, 1023), $urandom_range(0, 15),
                      $urandom_range(0, 1023), $urandom_range(0, 7));
      end
   endtask

   // stimulus and verdict
   initial begin
      int count;
      int phase;
      bit counted;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_parts_in_use(0);

      // empty table: nothing fits, nothing to release, unused code
      send_request(FUNC_ALLOC, 0, 0, 0, 0);
      send_request(FUNC_RELEASE, 0, 0, 0, 0);
      send_request(FuncUnused, 1023, 15, 1023, 7);

      // fill every entry; ties on length 100, zero and full-range lengths
      send_request(FUNC_LOAD, 100, 15, 0, 0);
      send_request(FUNC_LOAD, 1023, 0, 1023, 1);
      send_request(FUNC_LOAD, 100, 0, 200, 2);
      send_request(FUNC_LOAD, 0, 0, 300, 3);
      send_request(FUNC_LOAD, 500, 0, 400, 4);
      send_request(FUNC_LOAD, 50, 0, 512, 5);
      send_request(FUNC_LOAD, 100, 0, 600, 6);
      send_request(FUNC_LOAD, 700, 0, 700, 7);
      settle();
      write_parts_in_use(8);

      // best fit with ties, memory full, release of a free entry, release miss
      send_request(FUNC_ALLOC, 60, 15, 0, 0);
      send_request(FUNC_ALLOC, 60, 3, 0, 0);
      send_request(FUNC_ALLOC, 1023, 9, 0, 0);
      send_request(FUNC_ALLOC, 1023, 1, 0, 0);
      send_request(FUNC_ALLOC, 0, 0, 0, 0);
      send_request(FUNC_RELEASE, 0, 0, 1023, 0);
      send_request(FUNC_RELEASE, 0, 0, 1023, 0);
      send_request(FUNC_RELEASE, 0, 0, 5, 0);
      settle();

      // one entry in use: too big although larger entries exist beyond it
      write_parts_in_use(1);
      send_request(FUNC_ALLOC, 101, 2, 0, 0);
      settle();

      // register above table size counts as the full table
      write_parts_in_use(15);
      send_request(FUNC_ALLOC, 700, 4, 0, 0);
      settle();

      // random phases under different register settings
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       write_parts_in_use(8);
            1:       write_parts_in_use(3);
            2:       write_parts_in_use(15);
            3:       write_parts_in_use(1);
            4:       write_parts_in_use(0);
            default: write_parts_in_use($urandom_range(2, 8));
         endcase
         if (phase == 1) long_hold = 1'b1;
         if (phase == 5) idle_on = 1'b0;
         count = 0;
         while (count < PhaseItems) begin
            random_request(counted);
            if (counted) count++;
         end
         settle();
      end

      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
`default_nettype wire

/* filelist.f */
src/bfpa_pkg.sv
src/bfpa_table.sv
src/best_fit_partition_allocator.sv
sim/bfpa_checker.sv
sim/tb.sv
